// ===== sv/cdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the countdown timer channel bank.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DATA_W = 32;

    // Bit positions in a channel's control register.
    localparam int CTL_W      = 3;
    localparam int CTL_ENABLE = 0;
    localparam int CTL_RELOAD = 1;
    localparam int CTL_MASK   = 2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        REG_LOAD       = 3'd0,
        REG_CURRENT    = 3'd1,
        REG_CONTROL    = 3'd2,
        REG_INT_STATUS = 3'd3,
        REG_EOI        = 3'd4
    } t_reg_sel;

    // One beat as seen by a single channel, already qualified by the top level.
    typedef struct packed {
        logic              tick;
        logic              rd;
        logic              wr;
        t_reg_sel          sel;
        logic [DATA_W-1:0] data;
    } t_chan_req;

endpackage

// ===== sv/cdt_channel.sv =====
// ----------------------------------------------------------------------------
// cdt_channel
// One down-counting timer channel: load, current count, control and pending
// flag, with its register read data and next interrupt line.
// ----------------------------------------------------------------------------
module cdt_channel #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cdt_pkg::t_chan_req         i_req,
    output logic [cdt_pkg::DATA_W-1:0] o_rdata,
    output logic                       o_irq_next
);
    import cdt_pkg::*;

    logic [COUNT_WIDTH-1:0] r_load, n_load;
    logic [COUNT_WIDTH-1:0] r_cur, n_cur;
    logic [CTL_W-1:0]       r_ctl, n_ctl;
    logic                   r_pend, n_pend;
    logic [CTL_W-1:0]       wr_ctl;

    assign wr_ctl = i_req.data[CTL_W-1:0];

    always_comb begin
        n_load = r_load;
        n_cur  = r_cur;
        n_ctl  = r_ctl;
        n_pend = r_pend;

        if (i_req.tick && r_ctl[CTL_ENABLE]) begin
            if (r_cur == '0) begin
                n_pend = 1'b1;
                n_cur  = r_ctl[CTL_RELOAD] ? r_load : '1;
            end else begin
                n_cur = r_cur - 1'b1;
            end
        end

        if (i_req.wr) begin
            case (i_req.sel)
                REG_LOAD: begin
                    n_load = i_req.data[COUNT_WIDTH-1:0];
                end
                REG_CONTROL: begin
                    if (wr_ctl[CTL_ENABLE] && !r_ctl[CTL_ENABLE]) begin
                        n_cur = r_load;
                    end else if (!wr_ctl[CTL_ENABLE]) begin
                        n_cur = '1;
                    end
                    n_ctl = wr_ctl;
                end
                default: begin
                end
            endcase
        end

        if (i_req.rd && i_req.sel == REG_EOI) begin
            n_pend = 1'b0;
        end
    end

    // Reads see the state before this beat's side effects.
    always_comb begin
        o_rdata = '0;
        if (i_req.rd) begin
            case (i_req.sel)
                REG_LOAD:       o_rdata = DATA_W'(r_load);
                REG_CURRENT:    o_rdata = r_ctl[CTL_ENABLE] ? DATA_W'(r_cur)
                                                            : DATA_W'({COUNT_WIDTH{1'b1}});
                REG_CONTROL:    o_rdata = DATA_W'(r_ctl);
                REG_INT_STATUS: o_rdata = DATA_W'(r_pend && !r_ctl[CTL_MASK]);
                default:        o_rdata = '0;
            endcase
        end
    end

    assign o_irq_next = n_pend && !n_ctl[CTL_MASK];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
            r_cur  <= '1;
            r_ctl  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_load <= n_load;
            r_cur  <= n_cur;
            r_ctl  <= n_ctl;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== sv/countdown_timer_channels.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_channels
// Bank of down-counting timer channels with reload, behind a register port.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, o_stall, i_func, i_channel, i_reg_sel,
//   i_write_data) carries one beat per tick or register access. A tick counts
//   every enabled channel down; a read or write reaches one channel's load,
//   current, control, interrupt status or end-of-interrupt register.
//   The output channel (o_valid, i_stall, o_read_data, o_irq_lines) returns
//   exactly one beat per input beat, in order.
//   A beat is captured in the input register at its accepting edge; its
//   result is loaded into the output register when the beat advances, which
//   a full output register with the receiver stalling can hold off, and
//   o_valid then shows it. Throughput is one beat per cycle while the
//   receiver does not stall; each beat's state update is a single pass of
//   per-channel logic.
//   When the receiver stalls, the result register holds; the next beat waits
//   in the input register and o_stall rises only while both are occupied.
//   Reset clears every load count, disables and unmasks every channel, sets
//   current counts to all ones and clears the pending flags. No items are in
//   flight after reset.
// ----------------------------------------------------------------------------
module countdown_timer_channels #(
    parameter int NUM_CHANNELS = 8,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_func,
    input  logic [2:0]                 i_channel,
    input  logic [2:0]                 i_reg_sel,
    input  logic [cdt_pkg::DATA_W-1:0] i_write_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cdt_pkg::DATA_W-1:0] o_read_data,
    output logic [7:0]                 o_irq_lines
);
    import cdt_pkg::*;

    localparam int IRQ_LINES = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
    localparam logic [7:0] IRQ_USED = 8'((1 << IRQ_LINES) - 1);

    // Input register
    logic              r_in_valid;
    t_func             r_func;
    logic [2:0]        r_channel;
    t_reg_sel          r_reg_sel;
    logic [DATA_W-1:0] r_write_data;

    // Result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic [7:0]        r_irq, n_irq;

    logic advance;
    logic in_accept;

    logic [DATA_W-1:0] ch_rdata [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ch_irq;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func       <= t_func'(i_func);
            r_channel    <= i_channel;
            r_reg_sel    <= t_reg_sel'(i_reg_sel);
            r_write_data <= i_write_data;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        t_chan_req req;
        logic      hit;

        assign hit       = advance && (int'(r_channel) == g);
        assign req.tick  = advance && (r_func == FUNC_TICK);
        assign req.rd    = hit && (r_func == FUNC_READ);
        assign req.wr    = hit && (r_func == FUNC_WRITE);
        assign req.sel   = r_reg_sel;
        assign req.data  = r_write_data;

        cdt_channel #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_channel (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_req      (req),
            .o_rdata    (ch_rdata[g]),
            .o_irq_next (ch_irq[g])
        );
    end

    // Only the addressed channel drives nonzero read data.
    always_comb begin
        n_read_data = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            n_read_data = n_read_data | ch_rdata[i];
        end
        n_irq = '0;
        for (int i = 0; i < IRQ_LINES; i++) begin
            n_irq[i] = ch_irq[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= n_read_data;
            r_irq       <= n_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_lines = r_irq;

    // A stalled result is never dropped.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid)
        else $error("stalled result beat was dropped");

    // A beat that moves on always lands in the result register.
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed beat did not reach the result register");

    // The input side only stalls when a beat is actually waiting.
    a_stall_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled without a waiting beat");

    // Interrupt lines exist only for implemented channels.
    a_irq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_irq_lines & ~IRQ_USED) == 8'd0)
        else $error("interrupt line set for a missing channel");

endmodule

// ===== test/countdown_timer_channels_tb.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_channels_tb
// Self-checking bench for the countdown timer channel bank. A short table of
// directed beats covers reset values, reload, masking, end-of-interrupt and
// ignored accesses. A long run of random ticks and register accesses follows,
// with small load counts so that channels wrap often. A beat-level model in
// the bench predicts results not fixed in the table. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module countdown_timer_channels_tb;
    import cdt_pkg::*;

    localparam int          NCH        = 8;
    localparam int          CW         = 32;
    localparam int          RAND_BEATS = 650;
    localparam logic [CW-1:0] COUNT_ALL = '1;

    // Codes the block must tolerate but does not define.
    localparam logic [1:0] FUNC_NONE  = 2'd3;
    localparam logic [2:0] REG_SPARE5 = 3'd5;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [7:0]        irq;
    } t_beat_result;

    typedef struct {
        logic [1:0]        func;
        logic [2:0]        chan;
        logic [2:0]        sel;
        logic [DATA_W-1:0] data;
        bit                fixed;
        logic [DATA_W-1:0] rd;
        logic [7:0]        irq;
    } t_stim_row;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [1:0]        i_func       = FUNC_TICK;
    logic [2:0]        i_channel    = '0;
    logic [2:0]        i_reg_sel    = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic [7:0]        o_irq_lines;

    // Bench copy of the channel state.
    logic [CW-1:0]    load_cnt [NCH];
    logic [CW-1:0]    live_cnt [NCH];
    logic [CTL_W-1:0] ctl_reg  [NCH];
    logic             irq_flag [NCH];

    t_beat_result owed_results[$];
    int           mismatches = 0;
    int           stall_left = 0;
    bit           calm       = 1'b0;

    countdown_timer_channels #(
        .NUM_CHANNELS(NCH),
        .COUNT_WIDTH (CW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_reg_sel   (i_reg_sel),
        .i_write_data(i_write_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_data (o_read_data),
        .o_irq_lines (o_irq_lines)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("countdown_timer_channels: mismatch");
        $finish;
    end

    function automatic void clear_bank();
        for (int i = 0; i < NCH; i++) begin
            load_cnt[i] = '0;
            live_cnt[i] = COUNT_ALL;
            ctl_reg[i]  = '0;
            irq_flag[i] = 1'b0;
        end
    endfunction

    function automatic void timer_bank_step(input logic [1:0] f, input logic [2:0] ch,
                                            input logic [2:0] sel, input logic [DATA_W-1:0] wd,
                                            output t_beat_result res);
        logic [CTL_W-1:0] nv;
        res = '0;
        nv  = wd[CTL_W-1:0];
        case (f)
            FUNC_TICK: begin
                for (int i = 0; i < NCH; i++) begin
                    if (ctl_reg[i][CTL_ENABLE]) begin
                        if (live_cnt[i] == '0) begin
                            irq_flag[i] = 1'b1;
                            live_cnt[i] = ctl_reg[i][CTL_RELOAD] ? load_cnt[i] : COUNT_ALL;
                        end else begin
                            live_cnt[i] = live_cnt[i] - 1'b1;
                        end
                    end
                end
            end
            FUNC_READ: begin
                case (sel)
                    REG_LOAD:       res.rd = load_cnt[ch];
                    REG_CURRENT:    res.rd = ctl_reg[ch][CTL_ENABLE] ? live_cnt[ch] : COUNT_ALL;
                    REG_CONTROL:    res.rd = DATA_W'(ctl_reg[ch]);
                    REG_INT_STATUS: res.rd = DATA_W'(irq_flag[ch] & ~ctl_reg[ch][CTL_MASK]);
                    REG_EOI:        irq_flag[ch] = 1'b0;
                    default: ;
                endcase
            end
            FUNC_WRITE: begin
                if (sel == REG_LOAD) begin
                    load_cnt[ch] = wd[CW-1:0];
                end else if (sel == REG_CONTROL) begin
                    // Enabling from off starts at the load count; turning off parks at all ones.
                    if (nv[CTL_ENABLE] && !ctl_reg[ch][CTL_ENABLE])
                        live_cnt[ch] = load_cnt[ch];
                    else if (!nv[CTL_ENABLE])
                        live_cnt[ch] = COUNT_ALL;
                    ctl_reg[ch] = nv;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NCH && i < 8; i++)
            res.irq[i] = irq_flag[i] & ~ctl_reg[i][CTL_MASK];
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("error: %s expected %h got %h", what, want, seen);
    endfunction

    task automatic issue_beat(input logic [1:0] f, input logic [2:0] ch, input logic [2:0] sel,
                              input logic [DATA_W-1:0] wd, input bit fixed,
                              input t_beat_result want);
        t_beat_result got;
        int           gap;
        gap = (!calm && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= f;
        i_channel    <= ch;
        i_reg_sel    <= sel;
        i_write_data <= wd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        timer_bank_step(f, ch, sel, wd, got);
        owed_results.push_back(fixed ? want : got);
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            i_stall    <= 1'b1;
            stall_left <= idle_len() - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_beat_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_results.size() == 0) begin
                note_mismatch("result beat with none owed", '0, o_read_data);
            end else begin
                want = owed_results.pop_front();
                if (o_read_data !== want.rd)
                    note_mismatch("read_data", want.rd, o_read_data);
                if (o_irq_lines !== want.irq)
                    note_mismatch("irq_lines", DATA_W'(want.irq), DATA_W'(o_irq_lines));
            end
        end
    end

    initial begin
        t_stim_row    rows[25];
        t_beat_result want;
        logic [1:0]   f;
        logic [2:0]   ch;
        logic [2:0]   sel;
        logic [DATA_W-1:0] wd;
        int           r;

        rows = '{
            '{FUNC_READ,  3'd0, REG_CURRENT,    32'h0,        1, COUNT_ALL,    8'h00},
            '{FUNC_READ,  3'd0, REG_LOAD,       32'h0,        1, 32'h0,        8'h00},
            '{FUNC_READ,  3'd7, REG_CONTROL,    32'h0,        1, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_LOAD,       32'h2,        1, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_CONTROL,    32'h3,        1, 32'h0,        8'h00},
            '{FUNC_READ,  3'd0, REG_CURRENT,    32'h0,        1, 32'h2,        8'h00},
            '{FUNC_TICK,  3'd0, REG_LOAD,       32'h0,        0, 32'h0,        8'h00},
            '{FUNC_TICK,  3'd0, REG_LOAD,       32'h0,        0, 32'h0,        8'h00},
            '{FUNC_TICK,  3'd0, REG_LOAD,       32'h0,        1, 32'h0,        8'h01},
            '{FUNC_READ,  3'd0, REG_INT_STATUS, 32'h0,        1, 32'h1,        8'h01},
            '{FUNC_WRITE, 3'd0, REG_CONTROL,    32'h7,        1, 32'h0,        8'h00},
            '{FUNC_READ,  3'd0, REG_INT_STATUS, 32'h0,        1, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_CONTROL,    32'h3,        1, 32'h0,        8'h01},
            '{FUNC_READ,  3'd0, REG_EOI,        32'h0,        1, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_CURRENT,    32'h5,        0, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_SPARE5,     32'hffffffff, 0, 32'h0,        8'h00},
            '{FUNC_READ,  3'd0, REG_SPARE7,     32'h0,        1, 32'h0,        8'h00},
            '{FUNC_NONE,  3'd0, REG_LOAD,       32'hffffffff, 1, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_LOAD,       32'hffffffff, 0, 32'h0,        8'h00},
            '{FUNC_READ,  3'd0, REG_CURRENT,    32'h0,        0, 32'h0,        8'h00},
            '{FUNC_WRITE, 3'd0, REG_CONTROL,    32'h0,        1, 32'h0,        8'h00},
            '{FUNC_READ,  3'd0, REG_CURRENT,    32'h0,        1, COUNT_ALL,    8'h00},
            '{FUNC_WRITE, 3'd1, REG_CONTROL,    32'hfffffff9, 0, 32'h0,        8'h00},
            '{FUNC_TICK,  3'd0, REG_LOAD,       32'h0,        1, 32'h0,        8'h02},
            '{FUNC_WRITE, 3'd7, REG_CONTROL,    32'h1,        0, 32'h0,        8'h00}
        };

        clear_bank();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            want.rd  = rows[k].rd;
            want.irq = rows[k].irq;
            issue_beat(rows[k].func, rows[k].chan, rows[k].sel, rows[k].data,
                       rows[k].fixed, want);
        end

        for (int n = 0; n < RAND_BEATS; n++) begin
            // A stretch with no idling on either side.
            calm = (n >= 150 && n < 230);
            if (n == 400) begin
                i_valid <= 1'b0;
                while (owed_results.size() != 0) @(posedge i_clk);
            end
            r   = $urandom_range(0, 99);
            f   = (r < 38) ? FUNC_TICK : (r < 66) ? FUNC_READ : (r < 96) ? FUNC_WRITE : FUNC_NONE;
            ch  = 3'($urandom_range(0, NCH - 1));
            sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            wd  = $urandom();
            if (f == FUNC_WRITE) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    sel = REG_LOAD;
                    r   = $urandom_range(0, 99);
                    // Small loads make channels wrap within the run.
                    if (r < 65)
                        wd = $urandom_range(0, 6);
                    else if (r < 80)
                        wd = COUNT_ALL;
                end else if (r < 85) begin
                    sel = REG_CONTROL;
                end
            end
            issue_beat(f, ch, sel, wd, 1'b0, want);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("countdown_timer_channels: match");
        else
            $display("countdown_timer_channels: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cdt_pkg.sv
sv/cdt_channel.sv
sv/countdown_timer_channels.sv
test/countdown_timer_channels_tb.sv
